### rtl/savt_pkg.sv
`default_nettype none

package savt_pkg;

    // Width of one bitmap word searched by the second-level encoder
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned WORD_BIT_W = 5;

    localparam logic [31:0] ALLOC_FAIL = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_GET   = 2'd2,
        CMD_SET   = 2'd3
    } cmd_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // capture a transaction this cycle
        logic clear_we;  // write zero at the clearing address, advance it
        logic respond;   // form and register the result
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;  // clearing address is at the last slot
    } ctrl_stat_t;

endpackage

`default_nettype wire

### rtl/savt_ctrl.sv
`default_nettype none

module savt_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire savt_pkg::ctrl_stat_t stat,
    output      savt_pkg::ctrl_cmd_t  cmd,
    output      logic                busy
);
    import savt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_RESP  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.clear_we = 1'b0;
        cmd.respond  = 1'b0;
        busy         = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/savt_datapath.sv
`default_nettype none

module savt_datapath
#(
    parameter int unsigned NUM_SLOTS = 128
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire savt_pkg::ctrl_cmd_t  cmd,
    output      savt_pkg::ctrl_stat_t stat,
    input  wire logic [1:0]          command,
    input  wire logic [31:0]         slot_index,
    input  wire logic [31:0]         write_value,
    output      logic [31:0]         result_data,
    output      logic                ok,
    output      logic                done
);
    import savt_pkg::*;

    localparam int unsigned SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned NUM_WORDS  = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int unsigned WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned FULL_W     = WORD_IDX_W + WORD_BIT_W;

    // Used-bit map, one flop per slot
    logic [NUM_SLOTS-1:0]        used_reg;
    logic [NUM_SLOTS-1:0]        used_next;
    logic [NUM_WORDS*WORD_W-1:0] used_pad;
    logic [NUM_WORDS-1:0]        word_free;
    logic [WORD_IDX_W-1:0]       first_word;

    // Value table
    logic [31:0]       value_mem [NUM_SLOTS];
    logic [31:0]       rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic [SLOT_W-1:0] clr_addr_reg;

    // Captured transaction
    cmd_t                  cmd_reg;
    logic                  in_range_reg;
    logic [WORD_IDX_W-1:0] word_idx_reg;
    logic                  any_free_reg;

    logic                  in_range;
    cmd_t                  cmd_in;
    logic [WORD_W-1:0]     sel_word;
    logic [WORD_BIT_W-1:0] first_bit;
    logic [FULL_W-1:0]     alloc_slot;
    logic                  alloc_set;

    logic [31:0] result_data_reg;
    logic [31:0] result_data_next;
    logic        ok_reg;
    logic        ok_next;
    logic        done_reg;

    assign cmd_in   = cmd_t'(command);
    assign in_range = (slot_index < 32'(NUM_SLOTS));

    // Pad the map to whole words; pad bits read as used
    always_comb
    begin
        used_pad                  = '1;
        used_pad[NUM_SLOTS-1:0]   = used_reg;
    end

    // First level: lowest word with a free bit
    always_comb
    begin
        first_word = '0;
        for (int w = NUM_WORDS - 1; w >= 0; w--)
        begin
            word_free[w] = ~&used_pad[w*WORD_W +: WORD_W];
            if (word_free[w])
            begin
                first_word = WORD_IDX_W'(w);
            end
        end
    end

    // Second level: lowest free bit in the captured word
    always_comb
    begin
        sel_word  = used_pad[{word_idx_reg, {WORD_BIT_W{1'b0}}} +: WORD_W];
        first_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!sel_word[b])
            begin
                first_bit = WORD_BIT_W'(b);
            end
        end
        alloc_slot = {word_idx_reg, first_bit};
        alloc_set  = cmd.respond && (cmd_reg == CMD_ALLOC) && any_free_reg;
    end

    always_comb
    begin
        used_next = used_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (cmd.accept && (cmd_in == CMD_FREE) && in_range &&
                (slot_index[SLOT_W-1:0] == SLOT_W'(i)))
            begin
                used_next[i] = 1'b0;
            end
            if (alloc_set && (alloc_slot == FULL_W'(i)))
            begin
                used_next[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        result_data_next = '0;
        ok_next          = 1'b0;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                result_data_next = any_free_reg ? 32'(alloc_slot) : ALLOC_FAIL;
                ok_next          = any_free_reg;
            end
            CMD_FREE:
            begin
                ok_next = 1'b1;
            end
            CMD_GET:
            begin
                result_data_next = in_range_reg ? rd_data_reg : '0;
                ok_next          = in_range_reg;
            end
            CMD_SET:
            begin
                ok_next = in_range_reg;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            done_reg <= cmd.respond;
            if (cmd.clear_we)
            begin
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg      <= cmd_in;
            in_range_reg <= in_range;
            word_idx_reg <= first_word;
            any_free_reg <= |word_free;
        end
        if (cmd.respond)
        begin
            result_data_reg <= result_data_next;
            ok_reg          <= ok_next;
        end
    end

    // Single write port shared by the clearing pass and set
    assign mem_we    = cmd.clear_we ||
                       (cmd.accept && (cmd_in == CMD_SET) && in_range);
    assign mem_addr  = cmd.clear_we ? clr_addr_reg : slot_index[SLOT_W-1:0];
    assign mem_wdata = cmd.clear_we ? '0 : write_value;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.accept && in_range)
        begin
            rd_data_reg <= value_mem[slot_index[SLOT_W-1:0]];
        end
    end

    assign stat.clear_last = (clr_addr_reg == SLOT_W'(NUM_SLOTS - 1));
    assign result_data     = result_data_reg;
    assign ok              = ok_reg;
    assign done            = done_reg;

endmodule

`default_nettype wire

### rtl/slot_allocator_value_table_top.sv
`default_nettype none

// Slot allocator with a per-slot 32-bit value table. A transaction is taken
// at a rising edge with start high and busy low; its single result is
// registered on result_data/ok and done is high for exactly one cycle; the
// receiver cannot stall it, so capture it in that cycle. Each command has
// an accept cycle (first-level free-word search, value-table read or
// write, free of a used bit) and a response cycle (second-level search
// within the chosen 32-bit word, marking the slot used). busy drops again in
// the cycle in which done is high, so a new transaction may start there.
// After reset the value table is zeroed by a clearing pass over all
// NUM_SLOTS entries, one entry per cycle, with busy held high throughout.
module slot_allocator_value_table_top
#(
    parameter int unsigned NUM_SLOTS = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] slot_index,
    input  wire logic [31:0] write_value,
    output      logic [31:0] result_data,
    output      logic        ok,
    output      logic        done
);
    import savt_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Sequence clearing, accept and response
    savt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Bitmap, two-level free-slot search, value table and result register
    savt_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .command     (command),
        .slot_index  (slot_index),
        .write_value (write_value),
        .result_data (result_data),
        .ok          (ok),
        .done        (done)
    );

endmodule

`default_nettype wire
